### hdl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Types, constants and the CRC-16/Modbus byte update for the request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

   localparam int unsigned MSG_BYTES   = 6;
   localparam int unsigned FRAME_BYTES = 8;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  FUNC_READ  = 8'h03;
   localparam logic [7:0]  FUNC_WRITE = 8'h06;

   typedef enum logic {
      OP_READ_HOLDING = 1'b0,
      OP_WRITE_SINGLE = 1'b1
   } opcode_type;

   typedef logic [MSG_BYTES-1:0][7:0]   msg_type;
   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   typedef struct packed {
      msg_type     msg;
      logic [15:0] crc;
   } stage_type;

   // reflected CRC-16, one byte, bit at a time
   function automatic logic [15:0] crc_update_byte(input logic [15:0] crc_in,
                                                   input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

### hdl/mrf_interfaces.sv
// ----------------------------------------------------------------------------
// mrf_interfaces
// Valid/ready channels of the request framer: request, response, stage link.
// ----------------------------------------------------------------------------
interface mrf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  slave_address;
   logic        opcode;
   logic [15:0] register_address;
   logic [15:0] data_word;

   modport source (output valid, slave_address, opcode, register_address, data_word,
                   input ready);
   modport sink (input valid, slave_address, opcode, register_address, data_word,
                 output ready);
endinterface

interface mrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

interface mrf_stage_if
   import mrf_pkg::*;
   ;
   logic      valid;
   logic      ready;
   stage_type data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### hdl/mrf_crc_stage.sv
// ----------------------------------------------------------------------------
// mrf_crc_stage
// One pipeline stage: folds two message bytes into the running CRC.
// ----------------------------------------------------------------------------
module mrf_crc_stage
   import mrf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        byte_a,
   input  logic [7:0]        byte_b,
   mrf_stage_if.sink         up,
   mrf_stage_if.source       dn
);

   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;

   assign up.ready = !valid_ff || dn.ready;
   assign valid_in = up.ready ? up.valid : valid_ff;

   always_comb begin
      data_in     = up.data;
      data_in.crc = crc_update_byte(crc_update_byte(up.data.crc, byte_a), byte_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up.valid && up.ready) begin
         data_ff <= data_in;
      end
   end

   assign dn.valid = valid_ff;
   assign dn.data  = data_ff;

endmodule

### hdl/mrf_serializer.sv
// ----------------------------------------------------------------------------
// mrf_serializer
// Holds one finished frame and sends it out one byte per transaction.
// ----------------------------------------------------------------------------
module mrf_serializer
   import mrf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   mrf_stage_if.sink     up,
   mrf_rsp_if.source     rsp
);

   localparam logic [2:0] LAST_INDEX = 3'(FRAME_BYTES - 1);

   logic      valid_ff;
   logic      valid_in;
   logic [2:0] count_ff;
   logic [2:0] count_in;
   frame_type bytes_ff;
   logic      take;
   logic      at_last;
   logic      load;

   assign at_last  = (count_ff == LAST_INDEX);
   assign take     = valid_ff && rsp.ready;
   assign up.ready = !valid_ff || (rsp.ready && at_last);
   assign load     = up.valid && up.ready;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (load) begin
         valid_in = 1'b1;
         count_in = '0;
      end else if (take) begin
         valid_in = !at_last;
         count_in = count_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MSG_BYTES; i++) begin
            bytes_ff[i] <= up.data.msg[i];
         end
         bytes_ff[MSG_BYTES]   <= up.data.crc[7:0];
         bytes_ff[MSG_BYTES+1] <= up.data.crc[15:8];
      end else if (take) begin
         bytes_ff <= {8'h00, bytes_ff[FRAME_BYTES-1:1]};
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.frame_byte = bytes_ff[0];
   assign rsp.last_byte  = at_last;

endmodule

### hdl/modbus_rtu_request_framer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// Builds the 8-byte Modbus RTU request frame with CRC-16/Modbus.
//
//   channel  dir  per transaction
//   req      in   slave address, opcode, register address, data word
//   rsp      out  one frame byte, last-byte flag
//
// Three CRC stages fold two bytes each; the serializer then emits 8 bytes.
// A taken request passes three CRC stage registers, then the serializer's
// frame register; the one-byte response channel bounds the request rate.
// A new request enters while the previous frame is still being sent.
// Synchronous active-high reset clears all valid bits; stalls hold data.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer
   import mrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mrf_req_if.sink    req,
   mrf_rsp_if.source  rsp
);

   mrf_stage_if s0 ();
   mrf_stage_if s1 ();
   mrf_stage_if s2 ();
   mrf_stage_if s3 ();

   assign s0.valid = req.valid;
   assign req.ready = s0.ready;

   always_comb begin
      s0.data.msg[0] = req.slave_address;
      s0.data.msg[1] = (opcode_type'(req.opcode) == OP_WRITE_SINGLE) ? FUNC_WRITE : FUNC_READ;
      s0.data.msg[2] = req.register_address[15:8];
      s0.data.msg[3] = req.register_address[7:0];
      s0.data.msg[4] = req.data_word[15:8];
      s0.data.msg[5] = req.data_word[7:0];
      s0.data.crc    = CRC_INIT;
   end

   mrf_crc_stage u_crc0 (
      .clock  (clock),
      .reset  (reset),
      .byte_a (s0.data.msg[0]),
      .byte_b (s0.data.msg[1]),
      .up     (s0),
      .dn     (s1)
   );

   mrf_crc_stage u_crc1 (
      .clock  (clock),
      .reset  (reset),
      .byte_a (s1.data.msg[2]),
      .byte_b (s1.data.msg[3]),
      .up     (s1),
      .dn     (s2)
   );

   mrf_crc_stage u_crc2 (
      .clock  (clock),
      .reset  (reset),
      .byte_a (s2.data.msg[4]),
      .byte_b (s2.data.msg[5]),
      .up     (s2),
      .dn     (s3)
   );

   mrf_serializer u_ser (
      .clock (clock),
      .reset (reset),
      .up    (s3),
      .rsp   (rsp)
   );

endmodule
